// File: hdl/tlvs_pkg.sv
`default_nettype none

package tlvs_pkg;

	// Record header is a tag byte and a two-byte big-endian length
	localparam int unsigned HeaderBytes = 3;

	localparam logic [1:0] ST_FOUND     = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_TRUNCATED = 2'd2;

	typedef enum logic [4:0] {
		PH_TAG     = 5'b00001,
		PH_LEN_HI  = 5'b00010,
		PH_LEN_LO  = 5'b00100,
		PH_VALUE   = 5'b01000,
		PH_DECIDED = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]  search_status;
		logic [15:0] value_offset;
		logic [15:0] value_length;
	} out_beat_t;

	// Result of one parser step towards the result register
	typedef struct packed {
		logic      valid;
		out_beat_t beat;
	} step_res_t;

endpackage

`default_nettype wire

// File: hdl/tlvs_in_reg.sv
`default_nettype none

module tlvs_in_reg (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  req_valid,
	output logic                 req_ready,
	input  tlvs_pkg::in_beat_t   req_data,
	input  wire                  advance,
	output logic                 valid_s1,
	output tlvs_pkg::in_beat_t   beat_s1
);
	import tlvs_pkg::*;

	// Take a new beat when empty or when the held beat moves on this cycle
	assign req_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_valid && req_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			beat_s1 <= req_data;
		end
	end

endmodule

`default_nettype wire

// File: hdl/tlvs_parser.sv
`default_nettype none

module tlvs_parser #(
	parameter int unsigned LENGTH_BITS = 16
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire  [7:0]           wanted_tag,
	input  tlvs_pkg::in_beat_t   beat_s1,
	input  wire                  step,
	output tlvs_pkg::step_res_t  res
);
	import tlvs_pkg::*;

	localparam int unsigned CW = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;
	localparam logic [LENGTH_BITS-1:0] PosMax = {LENGTH_BITS{1'b1}};

	phase_t                 phase_q, phase_n;
	logic [LENGTH_BITS-1:0] pos_q, pos_n;
	logic [15:0]            rec_len_q, rec_len_n;
	logic [15:0]            left_q, left_n;
	logic                   matched_q, matched_n;

	logic [15:0] len_lo;
	logic [15:0] left_dec;
	logic [CW:0] pos_x;
	logic [CW:0] off_fit;
	logic [CW:0] off_empty;
	logic        at_max;

	assign len_lo    = {rec_len_q[15:8], beat_s1.data_byte};
	assign left_dec  = left_q - 16'd1;
	assign pos_x     = (CW+1)'(pos_q);
	assign off_fit   = pos_x - (CW+1)'(rec_len_q) + (CW+1)'(1);
	assign off_empty = pos_x + (CW+1)'(1);
	assign at_max    = (pos_q == PosMax);

	always_comb begin
		phase_n   = phase_q;
		pos_n     = pos_q;
		rec_len_n = rec_len_q;
		left_n    = left_q;
		matched_n = matched_q;
		res       = '0;

		unique case (phase_q)
			PH_TAG: begin
				matched_n = (beat_s1.data_byte == wanted_tag);
				phase_n   = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				rec_len_n = {beat_s1.data_byte, 8'h00};
				phase_n   = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				rec_len_n = len_lo;
				left_n    = len_lo;
				if (len_lo != 16'd0) begin
					phase_n = PH_VALUE;
				end else if (!matched_q) begin
					phase_n = PH_TAG;
				end else begin
					// Empty value: starts one past this byte, if there is such a place
					res.valid = 1'b1;
					if (at_max) begin
						res.beat.search_status = ST_NOT_FOUND;
					end else begin
						res.beat.search_status = ST_FOUND;
						res.beat.value_offset  = off_empty[15:0];
					end
					phase_n = PH_DECIDED;
				end
			end
			PH_VALUE: begin
				left_n = left_dec;
				if (left_dec == 16'd0) begin
					if (matched_q) begin
						res.valid                = 1'b1;
						res.beat.search_status   = ST_FOUND;
						res.beat.value_offset    = off_fit[15:0];
						res.beat.value_length    = rec_len_q;
						phase_n                  = PH_DECIDED;
					end else begin
						phase_n = PH_TAG;
					end
				end
			end
			PH_DECIDED: begin
				phase_n = PH_DECIDED;
			end
			default: begin
				phase_n = PH_DECIDED;
			end
		endcase

		// End of message or position limit while still undecided
		if (phase_n != PH_DECIDED) begin
			if (beat_s1.last_byte) begin
				res.valid = 1'b1;
				if (phase_n == PH_VALUE && matched_n) begin
					res.beat.search_status = ST_TRUNCATED;
				end else begin
					res.beat.search_status = ST_NOT_FOUND;
				end
				phase_n = PH_DECIDED;
			end else if (at_max) begin
				res.valid              = 1'b1;
				res.beat.search_status = ST_NOT_FOUND;
				phase_n                = PH_DECIDED;
			end
		end

		if (beat_s1.last_byte) begin
			phase_n   = PH_TAG;
			pos_n     = '0;
			rec_len_n = '0;
			left_n    = '0;
			matched_n = 1'b0;
		end else if (!at_max) begin
			pos_n = pos_q + LENGTH_BITS'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_TAG;
			pos_q     <= '0;
			rec_len_q <= '0;
			left_q    <= '0;
			matched_q <= 1'b0;
		end else if (step) begin
			phase_q   <= phase_n;
			pos_q     <= pos_n;
			rec_len_q <= rec_len_n;
			left_q    <= left_n;
			matched_q <= matched_n;
		end
	end

endmodule

`default_nettype wire

// File: hdl/tlvs_out_reg.sv
`default_nettype none

module tlvs_out_reg (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  step,
	input  tlvs_pkg::step_res_t  res,
	output logic                 rsp_valid,
	input  wire                  rsp_ready,
	output tlvs_pkg::out_beat_t  rsp_data
);
	import tlvs_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (step && res.valid) begin
			rsp_valid <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res.valid) begin
			rsp_data <= res.beat;
		end
	end

endmodule

`default_nettype wire

// File: hdl/tlv_tag_search_parser_unit.sv
// TLV tag search parser.
// A message enters on the req channel one byte per beat, the last beat flagged
// by last_byte. Records are a tag byte, a big-endian 16-bit length and the value.
// The rsp channel gives exactly one beat per message: found (with the value's
// offset and length), not found, or truncated when a matching value runs past
// the end of the message. Bytes after a decision are dropped until last_byte.
// The cfg channel writes wanted_tag; it is always ready. The user must write it
// only while no message is in flight; the block itself does not enforce this.
// Pipeline: an accepted byte waits in the input register, is parsed there by
// combinational logic, and its result beat is registered as the byte advances.
// Throughput: one byte per cycle while nothing stalls (see Stall); the per-byte
// step is a counter and compare between the input and result registers.
// Stall: while a result waits on rsp_ready, bytes that give no result still
// advance; a byte that would give a result holds in the input register and
// req_ready drops once that register is full.
// Reset: asynchronous, active low; clears the parser, both valid flags and
// wanted_tag (to zero).
`default_nettype none

module tlv_tag_search_parser_unit #(
	parameter int unsigned LENGTH_BITS = 16
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cfg_valid,
	output logic                 cfg_ready,
	input  wire  [7:0]           cfg_data,
	input  wire                  req_valid,
	output logic                 req_ready,
	input  tlvs_pkg::in_beat_t   req_data,
	output logic                 rsp_valid,
	input  wire                  rsp_ready,
	output tlvs_pkg::out_beat_t  rsp_data
);
	import tlvs_pkg::*;

	logic       [7:0] wanted_tag_q;
	logic             valid_s1;
	in_beat_t         beat_s1;
	step_res_t        res;
	logic             advance;

	// Register write is taken on every cfg beat
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wanted_tag_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			wanted_tag_q <= cfg_data;
		end
	end

	// Advance the held byte unless it gives a result and the result slot is
	// occupied and not being drained this cycle
	assign advance = valid_s1 && (!res.valid || !rsp_valid || rsp_ready);

	tlvs_in_reg u_in_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.advance   (advance),
		.valid_s1  (valid_s1),
		.beat_s1   (beat_s1)
	);

	tlvs_parser #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.wanted_tag (wanted_tag_q),
		.beat_s1    (beat_s1),
		.step       (advance),
		.res        (res)
	);

	tlvs_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.res       (res),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

endmodule

`default_nettype wire

// File: hdl/tlvs_checker.sv
`default_nettype none

module tlvs_checker (
	input wire                  clk,
	input wire                  arst_n,
	input wire                  req_ready,
	input wire                  rsp_valid,
	input wire                  rsp_ready,
	input tlvs_pkg::out_beat_t  rsp_data
);
	import tlvs_pkg::*;

	// A stalled result beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result beat changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_data.search_status == ST_FOUND ||
			rsp_data.search_status == ST_NOT_FOUND ||
			rsp_data.search_status == ST_TRUNCATED))
		else $error("undefined search status");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.search_status != ST_FOUND |->
			rsp_data.value_offset == 16'd0 && rsp_data.value_length == 16'd0)
		else $error("offset or length set on a miss");

	// Input stalls only behind a waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> rsp_valid && !rsp_ready)
		else $error("input stalled with no result waiting");

endmodule

bind tlv_tag_search_parser_unit tlvs_checker u_tlvs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp_data  (rsp_data)
);

`default_nettype wire
